[src/glm_pkg.sv]
// Package: constants, command codes and state type for the glyph lookup text measure block.
`default_nettype none
package glm_pkg;

  // Default glyph table depth
  localparam int GLM_MAX_GLYPHS = 256;

  // Field widths
  localparam int CNT_W   = 9;
  localparam int IDX_W   = 8;
  localparam int CP_W    = 21;
  localparam int MET_W   = 16;
  localparam int HGT_W   = 15;
  localparam int CHAR_W  = 8;
  localparam int ACC_W   = 32;
  localparam int BOT_W   = 17;
  localparam int TW_W    = 16;
  localparam int TH_W    = 13;
  localparam int METRICS_W = 64;

  // Command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_CHECK  = 4'b0100,
    S_ACC    = 4'b1000
  } glm_state_t;

endpackage
`default_nettype wire

[src/glyph_lookup_text_measure.sv]
// Top level: glyph table memories, binary search controller and text extent accumulators.
//
// Glyph table and text extent unit. A load word (cmd 0) writes one sorted table slot; slots
// at or beyond MAX_GLYPHS are dropped. A measure word (cmd 1) looks its byte up by a
// lower-bound binary search over the first n slots, n being the searched-count register
// clipped to MAX_GLYPHS. The search makes one probe of the codepoint memory per cycle, then
// a confirm step checks the hit and reads the metrics memory, and an accumulate step
// follows. A search that ends past the last slot skips the confirm step, and an empty table
// goes straight to the accumulate step. One word is in work at a time. The word marked
// last_char waits in its accumulate step while the output register still holds an
// unaccepted result, then delivers the rounded-up width (saturated) and height on the
// output register, which holds them while the next word is accepted; the accumulators
// clear for the next string.
`default_nettype none
module glyph_lookup_text_measure
  import glm_pkg::*;
#(
  parameter int MAX_GLYPHS = GLM_MAX_GLYPHS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CNT_W-1:0]         cfg_wr_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_cmd,
  input  wire logic [IDX_W-1:0]         in_entry_index,
  input  wire logic [CP_W-1:0]          in_entry_codepoint,
  input  wire logic signed [MET_W-1:0]  in_entry_left,
  input  wire logic signed [MET_W-1:0]  in_entry_top,
  input  wire logic [HGT_W-1:0]         in_entry_height,
  input  wire logic signed [MET_W-1:0]  in_entry_advance,
  input  wire logic [CHAR_W-1:0]        in_char_code,
  input  wire logic                     in_last_char,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [TW_W-1:0]        out_text_width,
  output logic [TH_W-1:0]               out_text_height
);

  localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int CW = $clog2(MAX_GLYPHS + 1);

  // Table memories
  logic [CP_W-1:0]      cp_mem  [MAX_GLYPHS];
  logic [METRICS_W-1:0] met_mem [MAX_GLYPHS];
  logic [CP_W-1:0]      cp_q;
  logic [METRICS_W-1:0] met_q;

  // Control and accumulator registers
  glm_state_t                state_r, state_nxt;
  logic [CW-1:0]             lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]             mid_r, mid_nxt;
  logic [CHAR_W-1:0]         code_r;
  logic                      last_r;
  logic [CNT_W-1:0]          count_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [BOT_W-1:0]          bmax_r;
  logic                      started_r;
  logic                      out_valid_r;
  logic signed [TW_W-1:0]    out_w_r;
  logic [TH_W-1:0]           out_h_r;

  // Memory access controls
  logic                      cp_rd_en, met_rd_en, tbl_wr_en;
  logic [AW-1:0]             cp_rd_addr, met_rd_addr, tbl_wr_addr;

  // Search datapath
  logic                      in_acc, out_free, acc_go;
  logic [CW-1:0]             n_clip;
  logic [CW-1:0]             lo_s, hi_s;
  logic [CW:0]               mid_sum;
  logic [AW-1:0]             mid_s, mid_init;

  // Accumulate datapath
  logic signed [MET_W-1:0]   g_left, g_top, g_adv;
  logic [HGT_W-1:0]          g_height;
  logic signed [ACC_W+1:0]   w_full;
  logic signed [ACC_W-1:0]   w_sat;
  logic signed [BOT_W:0]     bottom;
  logic [BOT_W-1:0]          bmax_new;
  logic signed [ACC_W+1:0]   w_ceil;
  logic signed [TW_W-1:0]    w_pix;
  logic [BOT_W:0]            h_sum;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_text_width  = out_w_r;
  assign out_text_height = out_h_r;

  // Clip the searched count to the table depth
  assign n_clip   = (32'(count_r) > 32'(MAX_GLYPHS)) ? CW'(MAX_GLYPHS) : CW'(count_r);
  assign mid_init = AW'(n_clip >> 1);

  // One lower-bound step on the probed codepoint
  always_comb begin
    if (cp_q < {{(CP_W-CHAR_W){1'b0}}, code_r}) begin
      lo_s = CW'({1'b0, mid_r} + 1'b1);
      hi_s = hi_r;
    end else begin
      lo_s = lo_r;
      hi_s = CW'(mid_r);
    end
    mid_sum = {1'b0, lo_s} + {1'b0, hi_s};
    mid_s   = AW'(mid_sum >> 1);
  end

  // Table write from a load word
  assign tbl_wr_en   = in_acc && (in_cmd == CMD_LOAD) &&
                       (32'(in_entry_index) < 32'(MAX_GLYPHS));
  assign tbl_wr_addr = AW'(in_entry_index);

  // Hold the last word until the output register frees up
  assign out_free = !out_valid_r || out_ready;
  assign acc_go   = !last_r || out_free;

  // Sequence the search
  always_comb begin
    state_nxt   = state_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    cp_rd_en    = 1'b0;
    cp_rd_addr  = mid_init;
    met_rd_en   = 1'b0;
    met_rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_MEASURE)) begin
          lo_nxt  = '0;
          hi_nxt  = n_clip;
          mid_nxt = mid_init;
          if (n_clip != '0) begin
            cp_rd_en   = 1'b1;
            cp_rd_addr = mid_init;
            state_nxt  = S_SEARCH;
          end else begin
            met_rd_en   = 1'b1;
            met_rd_addr = '0;
            state_nxt   = S_ACC;
          end
        end
      end
      S_SEARCH: begin
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        if (lo_s < hi_s) begin
          mid_nxt    = mid_s;
          cp_rd_en   = 1'b1;
          cp_rd_addr = mid_s;
        end else if (lo_s < n_clip) begin
          cp_rd_en   = 1'b1;
          cp_rd_addr = AW'(lo_s);
          state_nxt  = S_CHECK;
        end else begin
          met_rd_en   = 1'b1;
          met_rd_addr = '0;
          state_nxt   = S_ACC;
        end
      end
      S_CHECK: begin
        met_rd_en   = 1'b1;
        met_rd_addr = (cp_q == {{(CP_W-CHAR_W){1'b0}}, code_r}) ? AW'(lo_r) : '0;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        if (acc_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Codepoint memory
  always_ff @(posedge clk) begin
    if (tbl_wr_en) begin
      cp_mem[tbl_wr_addr] <= in_entry_codepoint;
    end
    if (cp_rd_en) begin
      cp_q <= cp_mem[cp_rd_addr];
    end
  end

  // Metrics memory: left, top, height, advance from the low end
  always_ff @(posedge clk) begin
    if (tbl_wr_en) begin
      met_mem[tbl_wr_addr] <= {in_entry_advance, 1'b0, in_entry_height,
                               in_entry_top, in_entry_left};
    end
    if (met_rd_en) begin
      met_q <= met_mem[met_rd_addr];
    end
  end

  // Unpack the looked-up glyph and update the extents
  always_comb begin
    g_left   = met_q[15:0];
    g_top    = met_q[31:16];
    g_height = met_q[46:32];
    g_adv    = met_q[63:48];

    w_full = (ACC_W+2)'(acc_r) + (ACC_W+2)'(g_adv);
    if (!started_r) begin
      w_full = w_full - (ACC_W+2)'(g_left);
    end
    if (w_full > (ACC_W+2)'(34'sh0_7FFF_FFFF)) begin
      w_sat = 32'sh7FFF_FFFF;
    end else if (w_full < -(ACC_W+2)'(34'sh0_8000_0000)) begin
      w_sat = -32'sh8000_0000;
    end else begin
      w_sat = w_full[ACC_W-1:0];
    end

    bottom = (BOT_W+1)'(g_top) + $signed({3'b000, g_height});
    if (bottom > $signed({1'b0, bmax_r})) begin
      bmax_new = bottom[BOT_W-1:0];
    end else begin
      bmax_new = bmax_r;
    end

    // Round up to whole pixels
    w_ceil = ((ACC_W+2)'(w_sat) + 34'sd15) >>> 4;
    if (w_ceil > 34'sd32767) begin
      w_pix = 16'sh7FFF;
    end else if (w_ceil < -34'sd32768) begin
      w_pix = -16'sh8000;
    end else begin
      w_pix = w_ceil[TW_W-1:0];
    end
    h_sum = ({1'b0, bmax_new} + 18'd15) >> 4;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      acc_r       <= '0;
      bmax_r      <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      // Raise valid on a new result, else drop it once the word is taken
      if ((state_r == S_ACC) && acc_go && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_ACC) && acc_go) begin
        if (last_r) begin
          acc_r     <= '0;
          bmax_r    <= '0;
          started_r <= 1'b0;
        end else begin
          acc_r     <= w_sat;
          bmax_r    <= bmax_new;
          started_r <= 1'b1;
        end
      end
    end
  end

  // Search and payload registers
  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    if (in_acc) begin
      code_r <= in_char_code;
      last_r <= in_last_char;
    end
    if ((state_r == S_ACC) && acc_go && last_r) begin
      out_w_r <= w_pix;
      out_h_r <= h_sum[TH_W-1:0];
    end
  end

endmodule
`default_nettype wire
